### hdl/ilie_pkg.sv
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared types and codes for the indexed list: request operations, result
// status codes and the command that the control broadcasts to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ilie_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = POS_W + 1;

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_ERASE  = 3'd2,
        FN_RESIZE = 3'd3,
        FN_READ   = 3'd4,
        FN_WRITE  = 3'd5,
        FN_FRONT  = 3'd6,
        FN_BACK   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CM_IDLE,
        CM_PUT_AT,
        CM_SHIFT_UP,
        CM_SHIFT_DOWN,
        CM_FILL
    } cell_mode_t;

    // No cell has this index, so a read aimed here returns zero.
    localparam logic [IDX_W-1:0] NO_READ = '1;

    typedef struct packed {
        cell_mode_t               mode;
        logic [IDX_W-1:0]         lo;
        logic [IDX_W-1:0]         hi;
        logic [IDX_W-1:0]         rd_addr;
        logic signed [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

`default_nettype wire

### hdl/indexed_list_insert_erase.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Ordered list of signed words with append, insert, erase, resize, read,
// write, front and back, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// For each accepted request every cell shifts, loads or holds in
// the same clock edge, and the result (status, new length, read data) sits
// in an output register, so a new request is accepted in every cycle in
// which that register is empty or being taken. The list holds DEPTH words,
// and a request that would overflow it returns the full status unchanged.
`default_nettype none

module indexed_list_insert_erase #(
    parameter int DEPTH = 16
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire  logic [2:0]                         s_func,
    input  wire  logic [ilie_pkg::POS_W-1:0]         s_position,
    input  wire  logic [ilie_pkg::POS_W-1:0]         s_new_length,
    input  wire  logic signed [ilie_pkg::WORD_W-1:0] s_word_in,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic signed [ilie_pkg::WORD_W-1:0]       m_word_out,
    output logic [1:0]                               m_status,
    output logic [ilie_pkg::LEN_W-1:0]               m_length
);
    import ilie_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(DEPTH);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [WORD_W-1:0] m_word_out_reg;
    logic [1:0]               m_status_reg;
    logic [LEN_W-1:0]         m_length_reg;

    logic                     s_fire;
    logic [IDX_W-1:0]         cnt_i;
    logic [IDX_W-1:0]         pos_i;
    logic [IDX_W-1:0]         nlen_i;
    logic [IDX_W-1:0]         new_cnt;
    status_t                  status;
    cell_mode_t               mode;
    logic [IDX_W-1:0]         lo;
    logic [IDX_W-1:0]         hi;
    logic [IDX_W-1:0]         rd_addr;
    cell_cmd_t                cmd;
    logic signed [WORD_W-1:0] rd_data;

    logic signed [WORD_W-1:0] cell_word [DEPTH];
    logic signed [WORD_W-1:0] cell_rd   [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign cnt_i  = IDX_W'(count_reg);
    assign pos_i  = {1'b0, s_position};
    assign nlen_i = {1'b0, s_new_length};

    always_comb begin
        status  = ST_OK;
        mode    = CM_IDLE;
        lo      = cnt_i;
        hi      = cnt_i;
        rd_addr = NO_READ;
        new_cnt = cnt_i;
        unique case (func_t'(s_func))
            FN_APPEND: begin
                if (cnt_i >= DEPTH_I) begin
                    status = ST_FULL;
                end else begin
                    mode    = CM_PUT_AT;
                    new_cnt = cnt_i + 1'b1;
                end
            end
            FN_INSERT: begin
                if (pos_i > cnt_i) begin
                    status = ST_INDEX;
                end else if (cnt_i >= DEPTH_I) begin
                    status = ST_FULL;
                end else begin
                    mode    = CM_SHIFT_UP;
                    lo      = pos_i;
                    new_cnt = cnt_i + 1'b1;
                end
            end
            FN_ERASE: begin
                if (pos_i >= cnt_i) begin
                    status = ST_INDEX;
                end else begin
                    mode    = CM_SHIFT_DOWN;
                    lo      = pos_i;
                    new_cnt = cnt_i - 1'b1;
                end
            end
            FN_RESIZE: begin
                if (nlen_i > DEPTH_I) begin
                    status = ST_FULL;
                end else begin
                    mode    = CM_FILL;
                    hi      = nlen_i;
                    new_cnt = nlen_i;
                end
            end
            FN_READ: begin
                if (pos_i >= cnt_i) begin
                    status = ST_INDEX;
                end else begin
                    rd_addr = pos_i;
                end
            end
            FN_WRITE: begin
                if (pos_i >= cnt_i) begin
                    status = ST_INDEX;
                end else begin
                    mode = CM_PUT_AT;
                    lo   = pos_i;
                end
            end
            FN_FRONT: begin
                if (cnt_i == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_addr = '0;
                end
            end
            FN_BACK: begin
                if (cnt_i == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_addr = cnt_i - 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        cmd.mode    = s_fire ? mode : CM_IDLE;
        cmd.lo      = lo;
        cmd.hi      = hi;
        cmd.rd_addr = rd_addr;
        cmd.word    = s_word_in;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = cell_word[i];
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        ilie_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .rd_word    (cell_rd[i])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_data = rd_data | cell_rd[i];
        end
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            count_next   = CW'(new_cnt);
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_word_out_reg <= rd_data;
            m_status_reg   <= status;
            m_length_reg   <= LEN_W'(new_cnt);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_word_out = m_word_out_reg;
    assign m_status   = m_status_reg;
    assign m_length   = m_length_reg;

endmodule

`default_nettype wire

### hdl/ilie_cell.sv
// ----------------------------------------------------------------------------
// ilie_cell
// One list slot. It loads the request word, takes its lower neighbor's word
// on insert, or its upper neighbor's word on erase, and drives its word on
// the read bus when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_cell #(
    parameter int INDEX = 0
) (
    input  wire                                    aclk,
    input  wire  ilie_pkg::cell_cmd_t              cmd,
    input  wire  logic signed [ilie_pkg::WORD_W-1:0] left_word,
    input  wire  logic signed [ilie_pkg::WORD_W-1:0] right_word,
    output logic signed [ilie_pkg::WORD_W-1:0]     word,
    output logic signed [ilie_pkg::WORD_W-1:0]     rd_word
);
    import ilie_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        unique case (cmd.mode)
            CM_IDLE: begin
                word_next = word_reg;
            end
            CM_PUT_AT: begin
                if (MY_IDX == cmd.lo) begin
                    word_next = cmd.word;
                end
            end
            CM_SHIFT_UP: begin
                if (MY_IDX == cmd.lo) begin
                    word_next = cmd.word;
                end else if (MY_IDX > cmd.lo) begin
                    word_next = left_word;
                end
            end
            CM_SHIFT_DOWN: begin
                if (MY_IDX >= cmd.lo) begin
                    word_next = right_word;
                end
            end
            CM_FILL: begin
                if (MY_IDX >= cmd.lo && MY_IDX < cmd.hi) begin
                    word_next = cmd.word;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (cmd.rd_addr == MY_IDX) ? word_reg : '0;

endmodule

`default_nettype wire

### hdl/ilie_checker.sv
// ----------------------------------------------------------------------------
// ilie_checker
// Port-level assertions for the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_checker #(
    parameter int DEPTH = 16
) (
    input wire                                      aclk,
    input wire                                      aresetn,
    input wire                                      s_valid,
    input wire                                      s_ready,
    input wire                                      m_valid,
    input wire                                      m_ready,
    input wire  logic signed [ilie_pkg::WORD_W-1:0] m_word_out,
    input wire  logic [1:0]                         m_status,
    input wire  logic [ilie_pkg::LEN_W-1:0]         m_length
);
    import ilie_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_out) && $stable(m_status)
            && $stable(m_length))
        else $error("stalled result changed");

    // Every accepted request produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    // The list never grows past its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_length) <= DEPTH)
        else $error("length beyond capacity");

    // An empty status only comes from an empty list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_length == '0)
        else $error("empty status with entries present");

    // A failed request returns no data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_word_out == '0)
        else $error("data returned with an error status");

endmodule

bind indexed_list_insert_erase ilie_checker #(
    .DEPTH (DEPTH)
) u_ilie_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_word_out (m_word_out),
    .m_status   (m_status),
    .m_length   (m_length)
);

`default_nettype wire

### verif/tb_indexed_list_insert_erase.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_erase
// Self-checking testbench for the indexed list with insert and erase.
// ----------------------------------------------------------------------------
// A queue of requests feeds a driver that works on the falling clock edge.
// The queue starts with a short directed sequence of edge cases and then
// holds random requests in grow, shrink and mixed phases. A monitor on the
// rising edge keeps its own copy of the list, works out the reply to every
// accepted request and compares each reply field by field. Both sides pause
// at random, the result side once holds off long enough to stall the input,
// and a watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_list_insert_erase;

    timeunit 1ns;
    timeprecision 1ps;

    import ilie_pkg::*;

    localparam int DEPTH        = 16;
    localparam int N_RANDOM     = 1700;
    localparam int GAP_PCT      = 14;
    localparam int QUIET_FROM   = 1200;
    localparam int QUIET_TO     = 1600;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        func_t                    func;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         new_length;
        logic signed [WORD_W-1:0] word;
    } list_req_t;

    typedef struct {
        logic signed [WORD_W-1:0] word;
        status_t                  status;
        logic [LEN_W-1:0]         len;
    } list_reply_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    wire                       s_ready;
    logic [2:0]                s_func = '0;
    logic [POS_W-1:0]          s_position = '0;
    logic [POS_W-1:0]          s_new_length = '0;
    logic signed [WORD_W-1:0]  s_word_in = '0;
    wire                       m_valid;
    logic                      m_ready = 1'b0;
    wire signed [WORD_W-1:0]   m_word_out;
    wire [1:0]                 m_status;
    wire [LEN_W-1:0]           m_length;

    list_req_t                 reqs_pending[$];
    list_reply_t               replies_due[$];
    logic signed [WORD_W-1:0]  list_mem[DEPTH];
    int                        list_len = 0;
    int                        cyc = 0;
    int                        stall_cnt = 0;
    logic                      s_took = 1'b0;
    bit                        bad = 1'b0;

    indexed_list_insert_erase #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .s_new_length (s_new_length),
        .s_word_in    (s_word_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_out   (m_word_out),
        .m_status     (m_status),
        .m_length     (m_length)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic queue_req(input func_t f, input int pos, input int nlen,
                             input logic signed [WORD_W-1:0] w);
        list_req_t r;
        r.func       = f;
        r.position   = pos[POS_W-1:0];
        r.new_length = nlen[POS_W-1:0];
        r.word       = w;
        reqs_pending = {reqs_pending, r};
    endtask

    task automatic queue_random_req(input int mode);
        func_t f;
        int    k;
        int    pos;
        int    nlen;
        k = $urandom_range(99);
        case (mode)
            0: begin
                if (k < 30)      f = FN_APPEND;
                else if (k < 55) f = FN_INSERT;
                else if (k < 65) f = FN_ERASE;
                else if (k < 70) f = FN_RESIZE;
                else             f = func_t'($urandom_range(4, 7));
            end
            1: begin
                if (k < 45)      f = FN_ERASE;
                else if (k < 55) f = FN_APPEND;
                else if (k < 60) f = FN_INSERT;
                else if (k < 65) f = FN_RESIZE;
                else             f = func_t'($urandom_range(4, 7));
            end
            default: f = func_t'($urandom_range(7));
        endcase
        pos  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(DEPTH + 1);
        nlen = ($urandom_range(6) == 0) ? $urandom_range(255) : $urandom_range(DEPTH + 1);
        queue_req(f, pos, nlen, $urandom);
    endtask

    task automatic predict_reply(input list_req_t r);
        list_reply_t e;
        int          n;
        int          p;
        int          nl;
        int          i;
        e.word   = '0;
        e.status = ST_OK;
        n  = list_len;
        p  = r.position;
        nl = r.new_length;
        case (r.func)
            FN_APPEND: begin
                if (n >= DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    list_mem[n] = r.word;
                    n++;
                end
            end
            FN_INSERT: begin
                if (p > n) begin
                    e.status = ST_INDEX;
                end else if (n >= DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    for (i = n; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = r.word;
                    n++;
                end
            end
            FN_ERASE: begin
                if (p >= n) begin
                    e.status = ST_INDEX;
                end else begin
                    for (i = p; i + 1 < n; i++) list_mem[i] = list_mem[i+1];
                    n--;
                end
            end
            FN_RESIZE: begin
                if (nl > DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    for (i = n; i < nl; i++) list_mem[i] = r.word;
                    n = nl;
                end
            end
            FN_READ: begin
                if (p >= n) e.status = ST_INDEX;
                else        e.word = list_mem[p];
            end
            FN_WRITE: begin
                if (p >= n) e.status = ST_INDEX;
                else        list_mem[p] = r.word;
            end
            FN_FRONT: begin
                if (n == 0) e.status = ST_EMPTY;
                else        e.word = list_mem[0];
            end
            default: begin
                if (n == 0) e.status = ST_EMPTY;
                else        e.word = list_mem[n-1];
            end
        endcase
        list_len = n;
        e.len = n[LEN_W-1:0];
        replies_due = {replies_due, e};
    endtask

    always @(negedge aclk) begin : drive_requests
        list_req_t r;
        logic      v;
        bit        gap;
        v   = s_valid;
        gap = (cyc < QUIET_FROM || cyc > QUIET_TO) && ($urandom_range(99) < GAP_PCT);
        if (!aresetn) begin
            v = 1'b0;
        end else if (!s_valid || s_took) begin
            v = 1'b0;
            if (reqs_pending.size() != 0 && !gap) begin
                r = reqs_pending.pop_front();
                v = 1'b1;
                s_func       <= r.func;
                s_position   <= r.position;
                s_new_length <= r.new_length;
                s_word_in    <= r.word;
            end
        end
        s_valid <= v;
    end

    always @(negedge aclk) begin : drive_result_ready
        int hold_left;
        if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (cyc >= QUIET_FROM && cyc <= QUIET_TO) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= GAP_PCT);
        end
    end

    always @(posedge aclk) begin : monitor
        list_req_t   r;
        list_reply_t e;
        cyc    <= cyc + 1;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: word_out %0d, status %0d, length %0d",
                           m_word_out, m_status, m_length);
                    bad = 1'b1;
                end else begin
                    e = replies_due.pop_front();
                    if (m_word_out !== e.word) begin
                        $error("word_out: expected %0d, actual %0d", e.word, m_word_out);
                        bad = 1'b1;
                    end
                    if (m_status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, m_status);
                        bad = 1'b1;
                    end
                    if (m_length !== e.len) begin
                        $error("length: expected %0d, actual %0d", e.len, m_length);
                        bad = 1'b1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                r.func       = func_t'(s_func);
                r.position   = s_position;
                r.new_length = s_new_length;
                r.word       = s_word_in;
                predict_reply(r);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("indexed_list_insert_erase: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int mode;
        int n;
        foreach (list_mem[i]) list_mem[i] = '0;

        // An empty list first: each read, write, erase and out-of-range insert on it reports an error.
        queue_req(FN_FRONT,  0, 0, 0);
        queue_req(FN_BACK,   0, 0, 0);
        queue_req(FN_READ,   0, 0, 0);
        queue_req(FN_ERASE,  0, 0, 0);
        queue_req(FN_WRITE,  0, 0, 32'sd5);
        queue_req(FN_INSERT, 1, 0, 32'sd7);
        queue_req(FN_INSERT, 0, 0, 32'sh7fffffff);
        queue_req(FN_APPEND, 0, 0, 32'sh80000000);
        queue_req(FN_APPEND, 0, 0, -32'sd1);
        queue_req(FN_INSERT, 3, 0, 32'sd0);
        queue_req(FN_READ,   255, 0, 0);
        queue_req(FN_FRONT,  0, 0, 0);
        queue_req(FN_BACK,   0, 0, 0);
        queue_req(FN_WRITE,  2, 0, 32'sh5a5a5a5a);
        queue_req(FN_ERASE,  0, 0, 0);
        queue_req(FN_READ,   1, 0, 0);
        queue_req(FN_RESIZE, 0, DEPTH, 32'sha5a5a5a5);
        queue_req(FN_APPEND, 0, 0, 32'sd1);
        queue_req(FN_INSERT, 4, 0, 32'sd2);
        queue_req(FN_INSERT, 17, 0, 32'sd3);
        queue_req(FN_RESIZE, 0, DEPTH + 1, 0);
        queue_req(FN_RESIZE, 0, 255, 0);
        queue_req(FN_RESIZE, 0, 0, 0);
        queue_req(FN_BACK,   0, 0, 0);
        queue_req(FN_RESIZE, 0, 3, -32'sd9);
        queue_req(FN_READ,   2, 0, 0);

        mode = 0;
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 60 == 0) mode = $urandom_range(2);
            queue_random_req(mode);
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (reqs_pending.size() != 0 || s_valid) @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!bad && replies_due.size() == 0) begin
            $display("indexed_list_insert_erase: match");
        end else begin
            $display("indexed_list_insert_erase: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hdl/ilie_pkg.sv
hdl/ilie_cell.sv
hdl/indexed_list_insert_erase.sv
hdl/ilie_checker.sv
verif/tb_indexed_list_insert_erase.sv
